// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, idle while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds around reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/hirb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hirb_pkg;

  localparam logic [2:0] KIND_MOVE        = 3'd0;
  localparam logic [2:0] KIND_BUTTON      = 3'd1;
  localparam logic [2:0] KIND_VSCROLL     = 3'd2;
  localparam logic [2:0] KIND_HSCROLL     = 3'd3;
  localparam logic [2:0] KIND_KEY         = 3'd4;
  localparam logic [2:0] KIND_RELEASE_ALL = 3'd5;

  localparam logic [1:0] REPORT_MOUSE    = 2'd0;
  localparam logic [1:0] REPORT_KEYBOARD = 2'd1;
  localparam logic [1:0] REPORT_RELEASE  = 2'd2;

  localparam int REPORT_SLOTS = 6;

  typedef struct packed {
    logic [7:0] mod_bit;
    logic [7:0] usage;
  } key_map_t;

endpackage

`default_nettype wire

// File: src/hirb_keymap.sv
`timescale 1ns / 1ps
`default_nettype none

module hirb_keymap
  import hirb_pkg::*;
(
  input  wire logic [7:0] virtual_key,
  output key_map_t        map
);

  logic [7:0] mod_bit;
  logic [7:0] usage;

  always_comb begin
    unique case (virtual_key)
      8'h10, 8'hA0: mod_bit = 8'h02;
      8'hA1:        mod_bit = 8'h20;
      8'h11, 8'hA2: mod_bit = 8'h01;
      8'hA3:        mod_bit = 8'h10;
      8'h12, 8'hA4: mod_bit = 8'h04;
      8'hA5:        mod_bit = 8'h40;
      8'h5B:        mod_bit = 8'h08;
      8'h5C:        mod_bit = 8'h80;
      default:      mod_bit = 8'h00;
    endcase
  end

  always_comb begin
    unique case (virtual_key) inside
      [8'h41:8'h5A]: usage = 8'h04 + (virtual_key - 8'h41);
      [8'h31:8'h39]: usage = 8'h1E + (virtual_key - 8'h31);
      8'h08: usage = 8'h2A;
      8'h09: usage = 8'h2B;
      8'h0D: usage = 8'h28;
      8'h13: usage = 8'h48;
      8'h14: usage = 8'h39;
      8'h1B: usage = 8'h29;
      8'h20: usage = 8'h2C;
      8'h21: usage = 8'h4B;
      8'h22: usage = 8'h4E;
      8'h23: usage = 8'h4D;
      8'h24: usage = 8'h4A;
      8'h25: usage = 8'h50;
      8'h26: usage = 8'h52;
      8'h27: usage = 8'h4F;
      8'h28: usage = 8'h51;
      8'h2C: usage = 8'h46;
      8'h2D: usage = 8'h49;
      8'h2E: usage = 8'h4C;
      8'h30: usage = 8'h27;
      8'h5D: usage = 8'h65;
      8'h60: usage = 8'h62;
      8'h61: usage = 8'h59;
      8'h62: usage = 8'h5A;
      8'h63: usage = 8'h5B;
      8'h64: usage = 8'h5C;
      8'h65: usage = 8'h5D;
      8'h66: usage = 8'h5E;
      8'h67: usage = 8'h5F;
      8'h68: usage = 8'h60;
      8'h69: usage = 8'h61;
      8'h6A: usage = 8'h55;
      8'h6B: usage = 8'h57;
      8'h6D: usage = 8'h56;
      8'h6E: usage = 8'h63;
      8'h6F: usage = 8'h54;
      8'h70: usage = 8'h3A;
      8'h71: usage = 8'h3B;
      8'h72: usage = 8'h3C;
      8'h73: usage = 8'h3D;
      8'h74: usage = 8'h3E;
      8'h75: usage = 8'h3F;
      8'h76: usage = 8'h40;
      8'h77: usage = 8'h41;
      8'h78: usage = 8'h42;
      8'h79: usage = 8'h43;
      8'h7A: usage = 8'h44;
      8'h7B: usage = 8'h45;
      8'h90: usage = 8'h53;
      8'h91: usage = 8'h47;
      8'hBA: usage = 8'h33;
      8'hBB: usage = 8'h2E;
      8'hBC: usage = 8'h36;
      8'hBD: usage = 8'h2D;
      8'hBE: usage = 8'h37;
      8'hBF: usage = 8'h38;
      8'hC0: usage = 8'h35;
      8'hDB: usage = 8'h2F;
      8'hDC: usage = 8'h31;
      8'hDD: usage = 8'h30;
      8'hDE: usage = 8'h34;
      default: usage = 8'h00;
    endcase
  end

  assign map.mod_bit = mod_bit;
  assign map.usage   = usage;

endmodule

`default_nettype wire

// File: src/hirb_slot_update.sv
`timescale 1ns / 1ps
`default_nettype none

module hirb_slot_update #(
  parameter int KEY_SLOTS = 6
) (
  input  wire logic [KEY_SLOTS-1:0][7:0] slots,
  input  wire logic [7:0]                usage,
  input  wire logic                      release_req,
  output logic      [KEY_SLOTS-1:0][7:0] slots_upd
);

  logic [KEY_SLOTS-1:0] hit;
  logic [KEY_SLOTS-1:0] empty;
  logic                 any_hit;
  logic                 done;

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      hit[i]   = (slots[i] == usage);
      empty[i] = (slots[i] == 8'h00);
    end
  end

  assign any_hit = |hit;

  // release clears the first match, press fills the first empty slot if the key is not held
  always_comb begin
    slots_upd = slots;
    done      = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (release_req) begin
        if (!done && hit[i]) begin
          slots_upd[i] = 8'h00;
          done         = 1'b1;
        end
      end else if (!any_hit) begin
        if (!done && empty[i]) begin
          slots_upd[i] = usage;
          done         = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/hid_input_report_builder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Builds boot style mouse and keyboard reports from input events. One item is
// taken every cycle while in_stall is low; an accepted item goes into the input
// register and its report into the result register, where it shows on the
// outputs until it is taken with out_stall low.
// Between the two registers sit the key code lookup and the KEY_SLOTS slot
// compares, which also update the button, modifier and slot state. Unmapped keys
// and unused event kinds give no report and do not advance the sequence number,
// which starts at 1 after reset and wraps at 32 bits. in_stall rises only while
// the input register holds an item and the result register holds a stalled report.

module hid_input_report_builder_top
  import hirb_pkg::*;
#(
  parameter int KEY_SLOTS = 6
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [2:0]   kind,
  input  wire logic signed [15:0] delta_x,
  input  wire logic signed [15:0] delta_y,
  input  wire logic signed [7:0]  wheel,
  input  wire logic [7:0]   btn_change,
  input  wire logic [7:0]   virtual_key,
  input  wire logic         release_req,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [1:0]        report_kind,
  output logic [31:0]       sequence_res,
  output logic [7:0]        buttons,
  output logic signed [15:0] out_dx,
  output logic signed [15:0] out_dy,
  output logic signed [7:0] wheel_vertical,
  output logic signed [7:0] wheel_horizontal,
  output logic [7:0]        modifiers,
  output logic [47:0]       key_slots
);

  localparam int SHOWN = (KEY_SLOTS < REPORT_SLOTS) ? KEY_SLOTS : REPORT_SLOTS;

  // input register
  logic                s1_valid;
  logic [2:0]          s1_kind;
  logic signed [15:0]  s1_dx;
  logic signed [15:0]  s1_dy;
  logic signed [7:0]   s1_wheel;
  logic [7:0]          s1_bmask;
  logic [7:0]          s1_vk;
  logic                s1_release;

  // block state
  logic [31:0]                 seq_counter;
  logic [7:0]                  button_state;
  logic [7:0]                  modifier_state;
  logic [KEY_SLOTS-1:0][7:0]   slot_store;

  logic [7:0]                  button_state_next;
  logic [7:0]                  modifier_state_next;
  logic [KEY_SLOTS-1:0][7:0]   slot_store_next;
  logic [KEY_SLOTS-1:0][7:0]   slots_upd;

  logic                has_result;
  logic [1:0]          rkind;
  logic signed [15:0]  res_dx;
  logic signed [15:0]  res_dy;
  logic signed [7:0]   res_wv;
  logic signed [7:0]   res_wh;
  logic [47:0]         packed_slots;
  logic                advance;
  key_map_t            map;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  hirb_keymap u_keymap (
    .virtual_key (s1_vk),
    .map         (map)
  );

  hirb_slot_update #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_slot_update (
    .slots       (slot_store),
    .usage       (map.usage),
    .release_req (s1_release),
    .slots_upd   (slots_upd)
  );

  always_comb begin
    has_result          = 1'b1;
    rkind               = REPORT_MOUSE;
    res_dx              = '0;
    res_dy              = '0;
    res_wv              = '0;
    res_wh              = '0;
    button_state_next   = button_state;
    modifier_state_next = modifier_state;
    slot_store_next     = slot_store;
    case (s1_kind)
      KIND_MOVE: begin
        res_dx = s1_dx;
        res_dy = s1_dy;
      end
      KIND_BUTTON: begin
        if (s1_release) begin
          button_state_next = button_state & ~s1_bmask;
        end else begin
          button_state_next = button_state | s1_bmask;
        end
      end
      KIND_VSCROLL: begin
        res_wv = s1_wheel;
      end
      KIND_HSCROLL: begin
        res_wh = s1_wheel;
      end
      KIND_KEY: begin
        rkind = REPORT_KEYBOARD;
        if (map.mod_bit != 8'h00) begin
          if (s1_release) begin
            modifier_state_next = modifier_state & ~map.mod_bit;
          end else begin
            modifier_state_next = modifier_state | map.mod_bit;
          end
        end else if (map.usage == 8'h00) begin
          has_result = 1'b0;
        end else begin
          slot_store_next = slots_upd;
        end
      end
      KIND_RELEASE_ALL: begin
        rkind               = REPORT_RELEASE;
        button_state_next   = '0;
        modifier_state_next = '0;
        slot_store_next     = '0;
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  always_comb begin
    packed_slots = '0;
    for (int i = 0; i < SHOWN; i++) begin
      packed_slots[i*8 +: 8] = slot_store_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_kind    <= kind;
      s1_dx      <= delta_x;
      s1_dy      <= delta_y;
      s1_wheel   <= wheel;
      s1_bmask   <= btn_change;
      s1_vk      <= virtual_key;
      s1_release <= release_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_counter    <= 32'd1;
      button_state   <= '0;
      modifier_state <= '0;
      slot_store     <= '0;
      out_valid      <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && has_result;
      if (s1_valid) begin
        button_state   <= button_state_next;
        modifier_state <= modifier_state_next;
        slot_store     <= slot_store_next;
        if (has_result) begin
          seq_counter <= seq_counter + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && has_result) begin
      report_kind      <= rkind;
      sequence_res     <= seq_counter;
      buttons          <= button_state_next;
      out_dx           <= res_dx;
      out_dy           <= res_dy;
      wheel_vertical   <= res_wv;
      wheel_horizontal <= res_wh;
      modifiers        <= modifier_state_next;
      key_slots        <= packed_slots;
    end
  end

endmodule

`default_nettype wire

// File: src/hirb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hirb_checker
  import hirb_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [1:0]        report_kind,
  input wire logic [31:0]       sequence_res,
  input wire logic [7:0]        buttons,
  input wire logic signed [15:0] out_dx,
  input wire logic signed [15:0] out_dy,
  input wire logic signed [7:0] wheel_vertical,
  input wire logic signed [7:0] wheel_horizontal,
  input wire logic [7:0]        modifiers,
  input wire logic [47:0]       key_slots
);

  logic        seen;
  logic [31:0] last_seq;
  logic        out_take;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_take) begin
      seen <= 1'b1;
    end
    if (out_take) begin
      last_seq <= sequence_res;
    end
  end

  `ASSERT_CLK_ALWAYS(a_no_item_after_reset, rst |=> !out_valid, "item right after reset")

  `ASSERT_CLK(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(sequence_res) && $stable(key_slots),
    "stalled item changed")

  `ASSERT_CLK(a_seq_step, out_take && seen |-> sequence_res == last_seq + 32'd1, "sequence gap")

  `ASSERT_CLK(a_release_clear,
    out_valid && report_kind == REPORT_RELEASE |->
      buttons == 8'h00 && modifiers == 8'h00 && key_slots == 48'h0 && out_dx == 16'sd0,
    "release-all not clear")

  `ASSERT_CLK(a_key_no_motion,
    out_valid && report_kind == REPORT_KEYBOARD |->
      out_dx == 16'sd0 && out_dy == 16'sd0 &&
      wheel_vertical == 8'sd0 && wheel_horizontal == 8'sd0,
    "motion in keyboard item")

endmodule

bind hid_input_report_builder_top hirb_checker u_hirb_checker (.*);

`default_nettype wire

// File: tb/hid_report_checker.sv
`timescale 1ns / 1ps

module hid_report_checker
  import hirb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         kind,
  input  logic signed [15:0] delta_x,
  input  logic signed [15:0] delta_y,
  input  logic signed [7:0]  wheel,
  input  logic [7:0]         btn_change,
  input  logic [7:0]         virtual_key,
  input  logic               release_req,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         report_kind,
  input  logic [31:0]        sequence_res,
  input  logic [7:0]         buttons,
  input  logic signed [15:0] out_dx,
  input  logic signed [15:0] out_dy,
  input  logic signed [7:0]  wheel_vertical,
  input  logic signed [7:0]  wheel_horizontal,
  input  logic [7:0]         modifiers,
  input  logic [47:0]        key_slots,
  output int                 mismatches,
  output int                 outstanding,
  output int                 compared
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [7:0]  buttons;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [7:0]  wv;
    logic [7:0]  wh;
    logic [7:0]  mods;
    logic [47:0] slots;
  } report_t;

  report_t     expected_reports[$];
  logic [31:0] seq_expect;
  logic [7:0]  held_buttons;
  logic [7:0]  held_modifiers;
  logic [7:0]  held_keys[REPORT_SLOTS];
  int          err_count = 0;
  int          done_count = 0;

  function automatic logic [7:0] vk_to_modifier(logic [7:0] vk);
    case (vk)
      8'h10, 8'hA0: return 8'h02;
      8'hA1:        return 8'h20;
      8'h11, 8'hA2: return 8'h01;
      8'hA3:        return 8'h10;
      8'h12, 8'hA4: return 8'h04;
      8'hA5:        return 8'h40;
      8'h5B:        return 8'h08;
      8'h5C:        return 8'h80;
      default:      return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] vk_to_usage(logic [7:0] vk);
    if (vk >= 8'h41 && vk <= 8'h5A) return vk - 8'h41 + 8'h04;
    if (vk >= 8'h31 && vk <= 8'h39) return vk - 8'h31 + 8'h1E;
    case (vk)
      8'h08: return 8'h2A;  8'h09: return 8'h2B;  8'h0D: return 8'h28;
      8'h13: return 8'h48;  8'h14: return 8'h39;  8'h1B: return 8'h29;
      8'h20: return 8'h2C;  8'h21: return 8'h4B;  8'h22: return 8'h4E;
      8'h23: return 8'h4D;  8'h24: return 8'h4A;  8'h25: return 8'h50;
      8'h26: return 8'h52;  8'h27: return 8'h4F;  8'h28: return 8'h51;
      8'h2C: return 8'h46;  8'h2D: return 8'h49;  8'h2E: return 8'h4C;
      8'h30: return 8'h27;  8'h5D: return 8'h65;
      8'h60: return 8'h62;  8'h61: return 8'h59;  8'h62: return 8'h5A;
      8'h63: return 8'h5B;  8'h64: return 8'h5C;  8'h65: return 8'h5D;
      8'h66: return 8'h5E;  8'h67: return 8'h5F;  8'h68: return 8'h60;
      8'h69: return 8'h61;  8'h6A: return 8'h55;  8'h6B: return 8'h57;
      8'h6D: return 8'h56;  8'h6E: return 8'h63;  8'h6F: return 8'h54;
      8'h70: return 8'h3A;  8'h71: return 8'h3B;  8'h72: return 8'h3C;
      8'h73: return 8'h3D;  8'h74: return 8'h3E;  8'h75: return 8'h3F;
      8'h76: return 8'h40;  8'h77: return 8'h41;  8'h78: return 8'h42;
      8'h79: return 8'h43;  8'h7A: return 8'h44;  8'h7B: return 8'h45;
      8'h90: return 8'h53;  8'h91: return 8'h47;
      8'hBA: return 8'h33;  8'hBB: return 8'h2E;  8'hBC: return 8'h36;
      8'hBD: return 8'h2D;  8'hBE: return 8'h37;  8'hBF: return 8'h38;
      8'hC0: return 8'h35;  8'hDB: return 8'h2F;  8'hDC: return 8'h31;
      8'hDD: return 8'h30;  8'hDE: return 8'h34;
      default: return 8'h00;
    endcase
  endfunction

  task automatic update_held_keys(input logic [7:0] usage, input logic rel);
    bit found;
    bit placed;
    found  = 1'b0;
    placed = 1'b0;
    for (int i = 0; i < REPORT_SLOTS; i++) begin
      if (!found && held_keys[i] == usage) begin
        found = 1'b1;
        if (rel) held_keys[i] = 8'h00;
      end
    end
    if (!found && !rel) begin
      for (int i = 0; i < REPORT_SLOTS; i++) begin
        if (!placed && held_keys[i] == 8'h00) begin
          held_keys[i] = usage;
          placed = 1'b1;
        end
      end
    end
  endtask

  task automatic apply_event(output bit made, output report_t r);
    logic [7:0] mod;
    logic [7:0] usage;
    made = 1'b1;
    r = '0;
    r.kind = REPORT_MOUSE;
    case (kind)
      KIND_MOVE: begin
        r.dx = delta_x;
        r.dy = delta_y;
      end
      KIND_BUTTON: begin
        if (release_req) held_buttons = held_buttons & ~btn_change;
        else held_buttons = held_buttons | btn_change;
      end
      KIND_VSCROLL: r.wv = wheel;
      KIND_HSCROLL: r.wh = wheel;
      KIND_KEY: begin
        r.kind = REPORT_KEYBOARD;
        mod = vk_to_modifier(virtual_key);
        if (mod != 8'h00) begin
          if (release_req) held_modifiers = held_modifiers & ~mod;
          else held_modifiers = held_modifiers | mod;
        end else begin
          usage = vk_to_usage(virtual_key);
          if (usage == 8'h00) made = 1'b0;
          else update_held_keys(usage, release_req);
        end
      end
      KIND_RELEASE_ALL: begin
        r.kind = REPORT_RELEASE;
        held_buttons   = 8'h00;
        held_modifiers = 8'h00;
        for (int i = 0; i < REPORT_SLOTS; i++) held_keys[i] = 8'h00;
      end
      default: made = 1'b0;
    endcase
    if (made) begin
      r.seq     = seq_expect;
      r.buttons = held_buttons;
      r.mods    = held_modifiers;
      for (int i = 0; i < REPORT_SLOTS; i++) r.slots[8*i +: 8] = held_keys[i];
      seq_expect = seq_expect + 32'd1;
    end
  endtask

  function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    report_t got;
    report_t want;
    bit      made;
    if (rst) begin
      seq_expect     = 32'd1;
      held_buttons   = 8'h00;
      held_modifiers = 8'h00;
      for (int i = 0; i < REPORT_SLOTS; i++) held_keys[i] = 8'h00;
      expected_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {report_kind, sequence_res, buttons, out_dx, out_dy, wheel_vertical,
               wheel_horizontal, modifiers, key_slots};
        if (expected_reports.size() == 0) begin
          $display("%0t: report with no event waiting: expected none, got seq %0h",
                   $time, sequence_res);
          err_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("report_kind", 48'(want.kind), 48'(got.kind));
          check_field("sequence_res", 48'(want.seq), 48'(got.seq));
          check_field("buttons", 48'(want.buttons), 48'(got.buttons));
          check_field("out_dx", 48'(want.dx), 48'(got.dx));
          check_field("out_dy", 48'(want.dy), 48'(got.dy));
          check_field("wheel_vertical", 48'(want.wv), 48'(got.wv));
          check_field("wheel_horizontal", 48'(want.wh), 48'(got.wh));
          check_field("modifiers", 48'(want.mods), 48'(got.mods));
          check_field("key_slots", want.slots, got.slots);
          done_count++;
        end
      end
      if (in_valid && !in_stall) begin
        apply_event(made, want);
        if (made) expected_reports.push_back(want);
      end
    end
    mismatches  <= err_count;
    outstanding <= expected_reports.size();
    compared    <= done_count;
  end

endmodule

// File: tb/hid_input_report_builder_top_tb.sv
`timescale 1ns / 1ps

module hid_input_report_builder_top_tb;
  import hirb_pkg::*;

  localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  localparam logic [7:0] KC_SHIFT_ANY = 8'h10;
  localparam logic [7:0] KC_CTRL_ANY  = 8'h11;
  localparam logic [7:0] KC_ALT_ANY   = 8'h12;
  localparam logic [7:0] KC_SHIFT_L   = 8'hA0;
  localparam logic [7:0] KC_SHIFT_R   = 8'hA1;
  localparam logic [7:0] KC_CTRL_L    = 8'hA2;
  localparam logic [7:0] KC_CTRL_R    = 8'hA3;
  localparam logic [7:0] KC_ALT_L     = 8'hA4;
  localparam logic [7:0] KC_ALT_R     = 8'hA5;
  localparam logic [7:0] KC_WIN_L     = 8'h5B;
  localparam logic [7:0] KC_WIN_R     = 8'h5C;
  localparam logic [7:0] KC_A         = 8'h41;
  localparam logic [7:0] KC_B         = 8'h42;
  localparam logic [7:0] KC_Z         = 8'h5A;
  localparam logic [7:0] KC_0         = 8'h30;
  localparam logic [7:0] KC_1         = 8'h31;
  localparam logic [7:0] KC_9         = 8'h39;
  localparam logic [7:0] KC_APPS      = 8'h5D;
  localparam logic [7:0] KC_ENTER     = 8'h0D;
  localparam logic [7:0] KC_F1        = 8'h70;
  localparam logic [7:0] KC_F12       = 8'h7B;
  localparam logic [7:0] KC_QUOTE     = 8'hDE;
  localparam logic [7:0] KC_UNMAPPED  = 8'h0A;

  localparam int RANDOM_ITEMS = 1250;
  localparam int QUIET_TAIL   = 150;
  localparam int IDLE_LIMIT   = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         kind = KIND_MOVE;
  logic signed [15:0] delta_x = '0;
  logic signed [15:0] delta_y = '0;
  logic signed [7:0]  wheel = '0;
  logic [7:0]         btn_change = '0;
  logic [7:0]         virtual_key = '0;
  logic               release_req = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         report_kind;
  logic [31:0]        sequence_res;
  logic [7:0]         buttons;
  logic signed [15:0] out_dx;
  logic signed [15:0] out_dy;
  logic signed [7:0]  wheel_vertical;
  logic signed [7:0]  wheel_horizontal;
  logic [7:0]         modifiers;
  logic [47:0]        key_slots;
  int                 mismatches;
  int                 outstanding;
  int                 compared;

  bit quiet = 1'b0;
  int sent = 0;
  int key_sent = 0;

  logic [7:0] key_pool[9] = '{KC_A, KC_B, KC_Z, KC_1, KC_0, KC_APPS, KC_ENTER, KC_F1,
                              KC_QUOTE};
  logic [7:0] mod_pool[11] = '{KC_SHIFT_ANY, KC_CTRL_ANY, KC_ALT_ANY, KC_SHIFT_L,
                               KC_SHIFT_R, KC_CTRL_L, KC_CTRL_R, KC_ALT_L, KC_ALT_R,
                               KC_WIN_L, KC_WIN_R};

  hid_input_report_builder_top dut (.*);

  hid_report_checker checker_i (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic send(input logic [2:0] k, input logic [15:0] dx, input logic [15:0] dy,
                      input logic [7:0] wh, input logic [7:0] mask, input logic [7:0] vk,
                      input logic rel);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    kind        <= k;
    delta_x     <= dx;
    delta_y     <= dy;
    wheel       <= wh;
    btn_change  <= mask;
    virtual_key <= vk;
    release_req <= rel;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (k == KIND_KEY) key_sent++;
  endtask

  task automatic send_key(input logic [7:0] vk, input logic rel);
    send(KIND_KEY, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), vk, rel);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("hid_input_report_builder_top test failed");
    $finish;
  end

  initial begin : stimulus
    int         pick;
    logic [2:0] k;
    logic [7:0] vk;
    logic       rel;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // extremes of motion, buttons and wheel
    send(KIND_MOVE, 16'h8000, 16'h7FFF, 8'h00, 8'h00, 8'h00, 1'b0);
    send(KIND_MOVE, 16'h7FFF, 16'h8000, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send(KIND_BUTTON, 16'h0000, 16'h0000, 8'h00, 8'hFF, 8'h00, 1'b0);
    send(KIND_BUTTON, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h55, 8'hFF, 1'b1);
    send(KIND_VSCROLL, 16'h0000, 16'h0000, 8'h80, 8'h00, 8'h00, 1'b0);
    send(KIND_HSCROLL, 16'h0000, 16'h0000, 8'h7F, 8'h00, 8'h00, 1'b0);
    // modifiers, generic code acting as the left key
    send_key(KC_SHIFT_ANY, 1'b0);
    send_key(KC_CTRL_R, 1'b0);
    send_key(KC_ALT_ANY, 1'b0);
    send_key(KC_WIN_R, 1'b0);
    send_key(KC_WIN_L, 1'b0);
    send_key(KC_SHIFT_ANY, 1'b1);
    // fill all slots, repeat a held key, overflow, release of a key not held
    send_key(KC_A, 1'b0);
    send_key(KC_A, 1'b0);
    send_key(KC_Z, 1'b0);
    send_key(KC_1, 1'b0);
    send_key(KC_9, 1'b0);
    send_key(KC_0, 1'b0);
    send_key(KC_APPS, 1'b0);
    send_key(KC_ENTER, 1'b0);
    send_key(KC_F12, 1'b1);
    send_key(KC_1, 1'b1);
    send_key(KC_UNMAPPED, 1'b0);
    send(KIND_UNUSED_LO, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
         8'($urandom), 1'b0);
    send(KIND_UNUSED_HI, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
         8'($urandom), 1'b1);
    send(KIND_RELEASE_ALL, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
         8'($urandom), 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= RANDOM_ITEMS - QUIET_TAIL);
      pick = $urandom_range(0, 99);
      vk  = 8'($urandom);
      rel = 1'($urandom_range(0, 1));
      if (pick < 15) k = KIND_MOVE;
      else if (pick < 25) k = KIND_BUTTON;
      else if (pick < 33) k = KIND_VSCROLL;
      else if (pick < 40) k = KIND_HSCROLL;
      else if (pick < 45) k = KIND_RELEASE_ALL;
      else if (pick < 48) k = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      else begin
        k = KIND_KEY;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          vk  = key_pool[4'($urandom_range(0, 8))];
          rel = ($urandom_range(0, 9) < 4);
        end else if (pick < 8) begin
          vk = mod_pool[4'($urandom_range(0, 10))];
        end
      end
      send(k, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), vk, rel);
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("ran %0d events (%0d key events) through, %0d reports compared",
             sent, key_sent, compared);
    $display("full slots, repeated and unheld keys, unmapped keys and unused kinds included");
    if (mismatches == 0) begin
      $display("hid_input_report_builder_top test passed");
    end else begin
      $display("hid_input_report_builder_top test failed");
    end
    $finish;
  end

endmodule
